/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

/* rtl/tpc_pkg.sv */
package tpc_pkg;

  localparam int MAX_RANK = 8;
  localparam int AXIS_BITS = 8;
  localparam int ADDR_BITS = 40;

  localparam int AXES = 8;
  localparam int AXIS_IDX_BITS = 3;
  localparam int RANK_BITS = 4;
  localparam int RUN_BITS = ADDR_BITS + 1;
  localparam int SIZE_BITS = AXIS_BITS + 1;
  localparam int RUN_PROD_BITS = RUN_BITS + SIZE_BITS;
  localparam int STR_PROD_BITS = ADDR_BITS + SIZE_BITS;

  localparam int SIZES_BITS = 64;
  localparam int ORDER_BITS = 24;

  localparam int OUT_FIELDS_BITS = 2 * ADDR_BITS + RUN_BITS;
  localparam int M_TDATA_BITS = ((OUT_FIELDS_BITS + 7) / 8) * 8;
  localparam int S_TDATA_BITS = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam int PADDR_BITS = 6;
  localparam int PDATA_BITS = 64;
  localparam int REG_IDX_BITS = 3;
  localparam int REG_ADDR_LSB = 3;

  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;
  localparam reg_idx_t REG_SRC_BASE    = 3'd0;
  localparam reg_idx_t REG_DST_BASE    = 3'd1;
  localparam reg_idx_t REG_TENSOR_RANK = 3'd2;
  localparam reg_idx_t REG_AXIS_SIZES  = 3'd3;
  localparam reg_idx_t REG_AXIS_ORDER  = 3'd4;

  typedef logic [0:0] kind_t;
  localparam kind_t KIND_NEXT    = 1'b0;
  localparam kind_t KIND_RESTART = 1'b1;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  src_base;
    logic [ADDR_BITS-1:0]  dst_base;
    logic [RANK_BITS-1:0]  tensor_rank;
    logic [SIZES_BITS-1:0] axis_sizes;
    logic [ORDER_BITS-1:0] axis_order;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } queue_head_t;

  function automatic logic [AXIS_BITS-1:0] axis_max(
    input logic [SIZES_BITS-1:0]    sizes,
    input logic [AXIS_IDX_BITS-1:0] k
  );
    return sizes[8*int'(k) +: AXIS_BITS];
  endfunction

  function automatic logic [AXIS_IDX_BITS-1:0] axis_src(
    input logic [ORDER_BITS-1:0]    order,
    input logic [AXIS_IDX_BITS-1:0] k
  );
    return order[3*int'(k) +: AXIS_IDX_BITS];
  endfunction

endpackage

/* rtl/tpc_front.sv */
module tpc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: restart in bit 0, zero padding above.
  input  logic [tpc_pkg::S_TDATA_BITS-1:0]    s_tdata,
  input  logic                                pop,
  output tpc_pkg::queue_head_t                head
);

  logic [tpc_pkg::QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [tpc_pkg::QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [tpc_pkg::QUEUE_PTR_BITS:0]   fill;
  tpc_pkg::kind_t                     slot [tpc_pkg::QUEUE_DEPTH];
  tpc_pkg::kind_t                     item_kind;
  logic                               push;

  assign s_tready  = fill != (tpc_pkg::QUEUE_PTR_BITS+1)'(tpc_pkg::QUEUE_DEPTH);
  assign push      = s_tvalid && s_tready;
  assign item_kind = s_tdata[0] ? tpc_pkg::KIND_RESTART : tpc_pkg::KIND_NEXT;

  assign head.valid = fill != '0;
  assign head.kind  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item_kind;
    end
  end

endmodule

/* rtl/tpc_back.sv */
module tpc_back (
  input  logic                                clk,
  input  logic                                rst,
  input  tpc_pkg::cfg_t                       cfg,
  input  tpc_pkg::queue_head_t                head,
  output logic                                pop,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: src_addr, dst_addr, run_length from bit 0 up, zero padding above.
  output logic [tpc_pkg::M_TDATA_BITS-1:0]    m_tdata,
  output logic                                m_tlast
);

  localparam logic [1:0] ST_RUN    = 2'd0;
  localparam logic [1:0] ST_RUNLEN = 2'd1;
  localparam logic [1:0] ST_STRIDE = 2'd2;

  localparam int AB  = tpc_pkg::ADDR_BITS;
  localparam int RB  = tpc_pkg::RUN_BITS;
  localparam int KB  = tpc_pkg::RANK_BITS;
  localparam int IB  = tpc_pkg::AXIS_IDX_BITS;
  localparam int NA  = tpc_pkg::AXES;
  localparam logic [RB-1:0] RUN_MAX = {1'b1, {AB{1'b0}}};

  logic [1:0]   state;
  logic [IB-1:0] step;
  logic         pass_done;

  logic [RB-1:0] run_acc;
  logic [KB-1:0] fixed_cnt;
  logic          still_fixed;
  logic [AB-1:0] str_acc;

  logic [KB-1:0] slow_axis_count;
  logic [RB-1:0] run_len_reg;
  logic [AB-1:0] src_offset;
  logic [AB-1:0] dst_offset;
  logic [tpc_pkg::AXIS_BITS-1:0] digit_counters [NA];
  logic [AB-1:0] source_strides [NA];
  logic [AB-1:0] level_offset [NA];

  logic [AB-1:0] out_src;
  logic [AB-1:0] out_dst;
  logic [RB-1:0] out_run;

  logic [KB-1:0]  rank_eff;
  logic [tpc_pkg::SIZE_BITS-1:0] cur_size;
  logic [tpc_pkg::RUN_PROD_BITS-1:0] run_prod;
  logic [RB-1:0]  run_sat;
  logic           axis_in_rank;
  logic           order_fixed;
  logic           fixed_hit;
  logic [RB-1:0]  run_next;
  logic [KB-1:0]  fixed_next;
  logic [KB-1:0]  slow_calc;
  logic [tpc_pkg::SIZE_BITS-1:0] ssz;
  logic [tpc_pkg::STR_PROD_BITS-1:0] str_prod;
  logic           mult_en;

  logic           out_free;
  logic           issue;
  logic           last_all;
  logic           hit;
  logic [IB-1:0]  hk;
  logic [AB-1:0]  new_top;

  assign rank_eff = (cfg.tensor_rank > KB'(tpc_pkg::MAX_RANK)) ?
                    KB'(tpc_pkg::MAX_RANK) : cfg.tensor_rank;

  assign cur_size     = {1'b0, tpc_pkg::axis_max(cfg.axis_sizes, step)} + 1'b1;
  assign run_prod     = tpc_pkg::RUN_PROD_BITS'(run_acc) *
                        tpc_pkg::RUN_PROD_BITS'(cur_size);
  assign run_sat      = (run_prod > tpc_pkg::RUN_PROD_BITS'(RUN_MAX)) ?
                        RUN_MAX : run_prod[RB-1:0];
  assign axis_in_rank = KB'(step) < rank_eff;
  assign order_fixed  = tpc_pkg::axis_src(cfg.axis_order, step) == step;
  assign fixed_hit    = axis_in_rank && still_fixed && order_fixed;
  assign run_next     = fixed_hit ? run_sat : run_acc;
  assign fixed_next   = fixed_hit ? fixed_cnt + 1'b1 : fixed_cnt;
  assign slow_calc    = rank_eff - fixed_next;

  always_comb begin
    ssz = tpc_pkg::SIZE_BITS'(1);
    for (int k = NA - 1; k >= 0; k--) begin
      if (KB'(k) < rank_eff && tpc_pkg::axis_src(cfg.axis_order, IB'(k)) == step) begin
        ssz = {1'b0, tpc_pkg::axis_max(cfg.axis_sizes, IB'(k))} + 1'b1;
      end
    end
  end

  assign str_prod = tpc_pkg::STR_PROD_BITS'(str_acc) * tpc_pkg::STR_PROD_BITS'(ssz);
  assign mult_en  = KB'(step) < slow_axis_count;

  assign out_free = !m_tvalid || m_tready;
  assign pop      = (state == ST_RUN) && head.valid &&
                    (head.kind == tpc_pkg::KIND_RESTART || pass_done || out_free);
  assign issue    = (state == ST_RUN) && head.valid &&
                    head.kind == tpc_pkg::KIND_NEXT && !pass_done && out_free;

  always_comb begin
    last_all = 1'b1;
    hit      = 1'b0;
    hk       = '0;
    for (int d = 0; d < NA; d++) begin
      if (KB'(d) < slow_axis_count) begin
        if (digit_counters[d] != tpc_pkg::axis_max(cfg.axis_sizes, IB'(d))) begin
          last_all = 1'b0;
        end
        if (digit_counters[d] < tpc_pkg::axis_max(cfg.axis_sizes, IB'(d))) begin
          hit = 1'b1;
          hk  = IB'(d);
        end
      end
    end
  end

  assign new_top = level_offset[hk] + source_strides[hk];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      step      <= '0;
      pass_done <= 1'b1;
      m_tvalid  <= 1'b0;
    end else begin
      if (issue) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_RUN: begin
          if (pop && head.kind == tpc_pkg::KIND_RESTART) begin
            state <= ST_RUNLEN;
            step  <= IB'(NA - 1);
          end else if (issue && last_all) begin
            pass_done <= 1'b1;
          end
        end
        ST_RUNLEN: begin
          if (step == '0) begin
            state <= ST_STRIDE;
            step  <= IB'(NA - 1);
          end else begin
            step <= step - 1'b1;
          end
        end
        ST_STRIDE: begin
          if (step == '0) begin
            state     <= ST_RUN;
            pass_done <= 1'b0;
          end else begin
            step <= step - 1'b1;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_RUN: begin
        if (pop && head.kind == tpc_pkg::KIND_RESTART) begin
          run_acc     <= RB'(1);
          fixed_cnt   <= '0;
          still_fixed <= 1'b1;
        end
        if (issue) begin
          out_src <= cfg.src_base + src_offset;
          out_dst <= cfg.dst_base + dst_offset;
          out_run <= run_len_reg;
          m_tlast <= last_all;
          if (!last_all) begin
            dst_offset <= dst_offset + run_len_reg[AB-1:0];
            src_offset <= hit ? new_top : '0;
            for (int j = 0; j < NA; j++) begin
              if (hit) begin
                if (IB'(j) == hk) begin
                  digit_counters[j] <= digit_counters[j] + 1'b1;
                end
                if (IB'(j) >= hk) begin
                  level_offset[j] <= new_top;
                end
                if (IB'(j) > hk && KB'(j) < slow_axis_count) begin
                  digit_counters[j] <= '0;
                end
              end else if (KB'(j) < slow_axis_count) begin
                digit_counters[j] <= '0;
                level_offset[j]   <= '0;
              end
            end
          end
        end
      end
      ST_RUNLEN: begin
        run_acc     <= run_next;
        fixed_cnt   <= fixed_next;
        still_fixed <= still_fixed && !(axis_in_rank && !order_fixed);
        if (step == '0) begin
          slow_axis_count <= slow_calc;
          run_len_reg     <= run_next;
          str_acc         <= run_next[AB-1:0];
        end
      end
      ST_STRIDE: begin
        for (int k = 0; k < NA; k++) begin
          if (tpc_pkg::axis_src(cfg.axis_order, IB'(k)) == step) begin
            source_strides[k] <= (KB'(k) < slow_axis_count) ? str_acc : '0;
          end
        end
        if (mult_en) begin
          str_acc <= str_prod[AB-1:0];
        end
        if (step == '0) begin
          src_offset <= '0;
          dst_offset <= '0;
          for (int k = 0; k < NA; k++) begin
            digit_counters[k] <= '0;
            level_offset[k]   <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = tpc_pkg::M_TDATA_BITS'({out_run, out_dst, out_src});

endmodule

/* rtl/tensor_permute_copy_address_gen_top.sv */
// Copy-command generator for an axis permutation of a dense tensor.
// Requests enter on the s_t* stream: restart = 1 starts a new pass and
// gives no command, restart = 0 asks for the next command of the pass.
// Commands leave on the m_t* stream with the source address, the
// destination address and the run length in m_tdata and the final
// command of a pass marked by m_tlast.
// The APB port holds the bases, rank, axis sizes and axis order; it
// answers every access at once and must only be written while idle.
// m_tvalid is registered behind the request queue; back-to-back
// requests give one command per cycle while m_tready stays high.
// A restart leaves the queue and then holds the command engine while it
// forms the run-length product and then the source strides, one
// multiply each cycle. A four-entry request queue keeps taking
// transfers then.
// When the receiver stalls, the command stays in the output register,
// the engine stops at the next command and the queue fills, after
// which s_tready falls. Reset clears the configuration, empties the
// queue and leaves no pass active, so requests give nothing until the
// first restart.
module tensor_permute_copy_address_gen_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tpc_pkg::PADDR_BITS-1:0]      paddr,
  input  logic [tpc_pkg::PDATA_BITS-1:0]      pwdata,
  output logic [tpc_pkg::PDATA_BITS-1:0]      prdata,
  output logic                                pready,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: restart in bit 0, zero padding above.
  input  logic [tpc_pkg::S_TDATA_BITS-1:0]    s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: src_addr, dst_addr, run_length from bit 0 up, zero padding above.
  output logic [tpc_pkg::M_TDATA_BITS-1:0]    m_tdata,
  output logic                                m_tlast
);

  tpc_pkg::cfg_t        cfg;
  tpc_pkg::queue_head_t head;
  tpc_pkg::reg_idx_t    reg_idx;
  logic                 cfg_write;
  logic                 pop;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[tpc_pkg::REG_ADDR_LSB +: tpc_pkg::REG_IDX_BITS];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx)
        tpc_pkg::REG_SRC_BASE:    cfg.src_base    <= pwdata[tpc_pkg::ADDR_BITS-1:0];
        tpc_pkg::REG_DST_BASE:    cfg.dst_base    <= pwdata[tpc_pkg::ADDR_BITS-1:0];
        tpc_pkg::REG_TENSOR_RANK: cfg.tensor_rank <= pwdata[tpc_pkg::RANK_BITS-1:0];
        tpc_pkg::REG_AXIS_SIZES:  cfg.axis_sizes  <= pwdata[tpc_pkg::SIZES_BITS-1:0];
        tpc_pkg::REG_AXIS_ORDER:  cfg.axis_order  <= pwdata[tpc_pkg::ORDER_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tpc_pkg::REG_SRC_BASE:    prdata = tpc_pkg::PDATA_BITS'(cfg.src_base);
      tpc_pkg::REG_DST_BASE:    prdata = tpc_pkg::PDATA_BITS'(cfg.dst_base);
      tpc_pkg::REG_TENSOR_RANK: prdata = tpc_pkg::PDATA_BITS'(cfg.tensor_rank);
      tpc_pkg::REG_AXIS_SIZES:  prdata = tpc_pkg::PDATA_BITS'(cfg.axis_sizes);
      tpc_pkg::REG_AXIS_ORDER:  prdata = tpc_pkg::PDATA_BITS'(cfg.axis_order);
      default:                  prdata = '0;
    endcase
  end

  tpc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .pop      (pop),
    .head     (head)
  );

  tpc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

/* rtl/tpc_checker.sv */
`include "assert_macros.svh"

module tpc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [tpc_pkg::M_TDATA_BITS-1:0] m_tdata,
  input logic                             m_tlast
);

  `ASSERT_CLK(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "stalled transfer dropped")
  `ASSERT_CLK(a_out_stable, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast), "stalled command changed")
  `ASSERT_CLK(a_run_nonzero, clk, rst, m_tvalid |-> m_tdata[120:80] != '0, "zero run length")
  `ASSERT_CLK_ALWAYS(a_reset_idle, clk, rst |=> !m_tvalid && s_tready, "not idle after reset")

endmodule

bind tensor_permute_copy_address_gen_top tpc_checker u_tpc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
